@@ hdl/tdpid_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpid_pkg
// Shared widths, register map, reset values and types of the two-axis
// incremental PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpid_pkg;

  // Field and datapath widths
  localparam int POS_W   = 24;   // position and target, signed Q8.16
  localparam int ERR_W   = 25;   // error, signed Q9.16
  localparam int GAIN_W  = 23;   // gains and limit, unsigned Q7.16
  localparam int INTEG_W = 25;   // integral term, signed
  localparam int SPEED_W = 32;   // speed command, signed Q16.16
  localparam int FRAC_W  = 16;   // fraction bits
  localparam int PROD_W  = 51;   // gain times error, 32 fraction bits
  localparam int PD_W    = PROD_W - FRAC_W;  // product rounded to 16 fraction bits
  localparam int SUM_W   = 37;   // new command before saturation

  // Configuration port
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_TARGET_X    = 3'd0;
  localparam logic [IDX_W-1:0] REG_TARGET_Y    = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_P      = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_D      = 3'd3;
  localparam logic [IDX_W-1:0] REG_GAIN_I_DT   = 3'd4;
  localparam logic [IDX_W-1:0] REG_INTEG_LIMIT = 3'd5;

  // Reset values
  localparam logic [GAIN_W-1:0] GAIN_P_RST      = 23'd196608;  // 3.0
  localparam logic [GAIN_W-1:0] GAIN_D_RST      = 23'd32768;   // 0.5
  localparam logic [GAIN_W-1:0] GAIN_I_DT_RST   = 23'd20644;   // 0.315
  localparam logic [GAIN_W-1:0] INTEG_LIMIT_RST = 23'd65536;   // 1.0

  // Register file contents seen by the datapath
  typedef struct packed {
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic [GAIN_W-1:0]       gain_p;
    logic [GAIN_W-1:0]       gain_d;
    logic [GAIN_W-1:0]       gain_i_dt;
    logic [GAIN_W-1:0]       integral_limit;
  } cfg_t;

  // Stage load enables from the pipeline control
  typedef struct packed {
    logic load_err;
    logic load_prod;
    logic load_sum;
    logic load_out;
  } pipe_ctrl_t;

  // Add one half and floor to 16 fraction bits (round half up)
  function automatic logic signed [PD_W-1:0] round_frac(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = v + {{(PROD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
    return t[PROD_W-1:FRAC_W];
  endfunction

endpackage

`default_nettype wire

@@ hdl/tdpid_if.sv @@
// ----------------------------------------------------------------------------
// tdpid_if
// Valid/ready stream interfaces for the position input and speed output.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdpid_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tdpid_pkg::POS_W-1:0]    pos_x;
  logic signed [tdpid_pkg::POS_W-1:0]    pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface tdpid_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tdpid_pkg::SPEED_W-1:0]  speed_x;
  logic signed [tdpid_pkg::SPEED_W-1:0]  speed_y;

  modport source (output valid, output speed_x, output speed_y, input ready);
  modport sink   (input valid, input speed_x, input speed_y, output ready);
endinterface

`default_nettype wire

@@ hdl/two_axis_incremental_pid.sv @@
// ----------------------------------------------------------------------------
// two_axis_incremental_pid
// Two-axis velocity-form PID controller with clamped integral, Q8.16 input,
// Q16.16 saturated speed output.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (valid/ready) carries one measured position pair pos_x, pos_y.
//   out_ch (valid/ready) carries the matching speed pair speed_x, speed_y;
//   every accepted position gives exactly one speed pair, in order.
//   The APB-style port sets targets, gains and the integral limit at byte
//   address 4*index; pready is always high, writes land at the access cycle.
//   Change registers only while no item is in flight.
// Timing:
//   Four register stages: error, gain products, rounded sums, output.
//   A result moves through the error, product, sum and output registers.
//   One item per cycle is sustained while out_ch.ready is high; the
//   recurrence on integral and command closes inside the output stage.
// Reset (rst_n low, synchronous): error history, integral and command state
//   clear to zero, registers return to their defaults, pipeline empties.
// Stall: when out_ch.ready is low the output holds; stages behind it keep
//   filling and in_ch.ready drops only once every stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module two_axis_incremental_pid (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  tdpid_in_if.sink                              in_ch,
  tdpid_out_if.source                           out_ch,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tdpid_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [tdpid_pkg::DATA_W-1:0]     pwdata,
  output logic      [tdpid_pkg::DATA_W-1:0]     prdata,
  output logic                                  pready
);

  tdpid_pkg::cfg_t       cfg;
  tdpid_pkg::pipe_ctrl_t ctrl;

  logic err_vld_r, prod_vld_r, sum_vld_r, out_vld_r;

  // Register file
  tdpid_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage loads: each stage moves when it holds an item and the next has room
  assign ctrl.load_out  = sum_vld_r  && (!out_vld_r  || out_ch.ready);
  assign ctrl.load_sum  = prod_vld_r && (!sum_vld_r  || ctrl.load_out);
  assign ctrl.load_prod = err_vld_r  && (!prod_vld_r || ctrl.load_sum);
  assign in_ch.ready    = !err_vld_r || ctrl.load_prod;
  assign ctrl.load_err  = in_ch.valid && in_ch.ready;

  // Track stage occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_vld_r  <= 1'b0;
      prod_vld_r <= 1'b0;
      sum_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (ctrl.load_err) begin
        err_vld_r <= 1'b1;
      end else if (ctrl.load_prod) begin
        err_vld_r <= 1'b0;
      end
      if (ctrl.load_prod) begin
        prod_vld_r <= 1'b1;
      end else if (ctrl.load_sum) begin
        prod_vld_r <= 1'b0;
      end
      if (ctrl.load_sum) begin
        sum_vld_r <= 1'b1;
      end else if (ctrl.load_out) begin
        sum_vld_r <= 1'b0;
      end
      if (ctrl.load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_vld_r;

  // Axis datapaths
  tdpid_axis u_axis_x (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .pos            (in_ch.pos_x),
    .target         (cfg.target_x),
    .gain_p         (cfg.gain_p),
    .gain_d         (cfg.gain_d),
    .gain_i_dt      (cfg.gain_i_dt),
    .integral_limit (cfg.integral_limit),
    .speed          (out_ch.speed_x)
  );

  tdpid_axis u_axis_y (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .pos            (in_ch.pos_y),
    .target         (cfg.target_y),
    .gain_p         (cfg.gain_p),
    .gain_d         (cfg.gain_d),
    .gain_i_dt      (cfg.gain_i_dt),
    .integral_limit (cfg.integral_limit),
    .speed          (out_ch.speed_y)
  );

endmodule

`default_nettype wire

@@ hdl/tdpid_cfg.sv @@
// ----------------------------------------------------------------------------
// tdpid_cfg
// APB-style register file: targets, gains and integral limit.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpid_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tdpid_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [tdpid_pkg::DATA_W-1:0]     pwdata,
  output logic      [tdpid_pkg::DATA_W-1:0]     prdata,
  output logic                                  pready,
  output tdpid_pkg::cfg_t                       cfg
);

  tdpid_pkg::cfg_t              cfg_r;
  logic [tdpid_pkg::IDX_W-1:0]  idx;
  logic                         wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[tdpid_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Update the addressed register on a write transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_x       <= '0;
      cfg_r.target_y       <= '0;
      cfg_r.gain_p         <= tdpid_pkg::GAIN_P_RST;
      cfg_r.gain_d         <= tdpid_pkg::GAIN_D_RST;
      cfg_r.gain_i_dt      <= tdpid_pkg::GAIN_I_DT_RST;
      cfg_r.integral_limit <= tdpid_pkg::INTEG_LIMIT_RST;
    end else if (wr_en) begin
      case (idx)
        tdpid_pkg::REG_TARGET_X:    cfg_r.target_x       <= pwdata[tdpid_pkg::POS_W-1:0];
        tdpid_pkg::REG_TARGET_Y:    cfg_r.target_y       <= pwdata[tdpid_pkg::POS_W-1:0];
        tdpid_pkg::REG_GAIN_P:      cfg_r.gain_p         <= pwdata[tdpid_pkg::GAIN_W-1:0];
        tdpid_pkg::REG_GAIN_D:      cfg_r.gain_d         <= pwdata[tdpid_pkg::GAIN_W-1:0];
        tdpid_pkg::REG_GAIN_I_DT:   cfg_r.gain_i_dt      <= pwdata[tdpid_pkg::GAIN_W-1:0];
        tdpid_pkg::REG_INTEG_LIMIT: cfg_r.integral_limit <= pwdata[tdpid_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, targets sign-extended
  always_comb begin
    case (idx)
      tdpid_pkg::REG_TARGET_X:
        prdata = {{(tdpid_pkg::DATA_W-tdpid_pkg::POS_W){cfg_r.target_x[tdpid_pkg::POS_W-1]}},
                  cfg_r.target_x};
      tdpid_pkg::REG_TARGET_Y:
        prdata = {{(tdpid_pkg::DATA_W-tdpid_pkg::POS_W){cfg_r.target_y[tdpid_pkg::POS_W-1]}},
                  cfg_r.target_y};
      tdpid_pkg::REG_GAIN_P:
        prdata = {{(tdpid_pkg::DATA_W-tdpid_pkg::GAIN_W){1'b0}}, cfg_r.gain_p};
      tdpid_pkg::REG_GAIN_D:
        prdata = {{(tdpid_pkg::DATA_W-tdpid_pkg::GAIN_W){1'b0}}, cfg_r.gain_d};
      tdpid_pkg::REG_GAIN_I_DT:
        prdata = {{(tdpid_pkg::DATA_W-tdpid_pkg::GAIN_W){1'b0}}, cfg_r.gain_i_dt};
      tdpid_pkg::REG_INTEG_LIMIT:
        prdata = {{(tdpid_pkg::DATA_W-tdpid_pkg::GAIN_W){1'b0}}, cfg_r.integral_limit};
      default:
        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/tdpid_axis.sv @@
// ----------------------------------------------------------------------------
// tdpid_axis
// One axis of the velocity-form PID: error history, gain products,
// rounding, clamped integral and saturated command update.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpid_axis (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  tdpid_pkg::pipe_ctrl_t                      ctrl,
  input  wire logic signed [tdpid_pkg::POS_W-1:0]    pos,
  input  wire logic signed [tdpid_pkg::POS_W-1:0]    target,
  input  wire logic        [tdpid_pkg::GAIN_W-1:0]   gain_p,
  input  wire logic        [tdpid_pkg::GAIN_W-1:0]   gain_d,
  input  wire logic        [tdpid_pkg::GAIN_W-1:0]   gain_i_dt,
  input  wire logic        [tdpid_pkg::GAIN_W-1:0]   integral_limit,
  output logic signed      [tdpid_pkg::SPEED_W-1:0]  speed
);

  localparam int ERR_W   = tdpid_pkg::ERR_W;
  localparam int GAIN_W  = tdpid_pkg::GAIN_W;
  localparam int PROD_W  = tdpid_pkg::PROD_W;
  localparam int PD_W    = tdpid_pkg::PD_W;
  localparam int INTEG_W = tdpid_pkg::INTEG_W;
  localparam int SPEED_W = tdpid_pkg::SPEED_W;
  localparam int SUM_W   = tdpid_pkg::SUM_W;
  localparam int ISUM_W  = PD_W + 1;

  // Signed 32-bit command limits, sign-extended to the sum width
  localparam logic signed [SUM_W-1:0] CMD_MAX =
    SUM_W'(signed'({1'b0, {(SPEED_W-1){1'b1}}}));
  localparam logic signed [SUM_W-1:0] CMD_MIN =
    SUM_W'(signed'({1'b1, {(SPEED_W-1){1'b0}}}));

  // Error history (state) and per-item error stage
  logic signed [ERR_W-1:0]  hist1_r, hist2_r;
  logic signed [ERR_W-1:0]  e0_r, e1_r, e2_r;
  logic signed [ERR_W-1:0]  e0_nxt;

  // Product stage
  logic        [GAIN_W:0]   coef_a;      // kp + kd
  logic        [GAIN_W+1:0] coef_b;      // kp + 2kd
  logic signed [PROD_W-1:0] prod_a_r, prod_b_r, prod_c_r, prod_i_r;
  logic signed [PROD_W-1:0] prod_a_nxt, prod_b_nxt, prod_c_nxt, prod_i_nxt;

  // Rounded sum stage
  logic signed [PROD_W-1:0] pd_sum;
  logic signed [PD_W-1:0]   pd_r, inc_r;

  // Output stage (state)
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [SPEED_W-1:0] speed_r, speed_nxt;
  logic signed [ISUM_W-1:0]  integ_sum, lim_pos, lim_neg;
  logic signed [INTEG_W:0]   integ_diff;
  logic signed [SUM_W-1:0]   cmd_sum;

  // Error of the incoming item, exact in 25 bits
  assign e0_nxt = ERR_W'(target) - ERR_W'(pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist1_r <= '0;
      hist2_r <= '0;
    end else if (ctrl.load_err) begin
      hist1_r <= e0_nxt;
      hist2_r <= hist1_r;
    end
  end

  // Capture the three errors that this item uses
  always_ff @(posedge clk) begin
    if (ctrl.load_err) begin
      e0_r <= e0_nxt;
      e1_r <= hist1_r;
      e2_r <= hist2_r;
    end
  end

  // Gain products, each exact with 32 fraction bits
  assign coef_a = {1'b0, gain_p} + {1'b0, gain_d};
  assign coef_b = {2'b00, gain_p} + {1'b0, gain_d, 1'b0};

  assign prod_a_nxt = signed'({2'b00, coef_a}) * e0_r;
  assign prod_b_nxt = signed'({1'b0, coef_b}) * e1_r;
  assign prod_c_nxt = signed'({1'b0, gain_d}) * e2_r;
  assign prod_i_nxt = signed'({1'b0, gain_i_dt}) * e0_r;

  always_ff @(posedge clk) begin
    if (ctrl.load_prod) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
      prod_c_r <= prod_c_nxt;
      prod_i_r <= prod_i_nxt;
    end
  end

  // Combine the PD products and round both terms
  assign pd_sum = prod_a_r - prod_b_r + prod_c_r;

  always_ff @(posedge clk) begin
    if (ctrl.load_sum) begin
      pd_r  <= tdpid_pkg::round_frac(pd_sum);
      inc_r <= tdpid_pkg::round_frac(prod_i_r);
    end
  end

  // Clamp the integral to the symmetric limit
  assign integ_sum = ISUM_W'(integ_r) + ISUM_W'(inc_r);
  assign lim_pos   = signed'(ISUM_W'(integral_limit));
  assign lim_neg   = -lim_pos;

  always_comb begin
    if (integ_sum > lim_pos) begin
      integ_nxt = INTEG_W'(lim_pos);
    end else if (integ_sum < lim_neg) begin
      integ_nxt = INTEG_W'(lim_neg);
    end else begin
      integ_nxt = INTEG_W'(integ_sum);
    end
  end

  // Advance the command and saturate to 32 bits
  assign integ_diff = (INTEG_W+1)'(integ_nxt) - (INTEG_W+1)'(integ_r);
  assign cmd_sum    = SUM_W'(speed_r) + SUM_W'(pd_r) + SUM_W'(integ_diff);

  always_comb begin
    if (cmd_sum > CMD_MAX) begin
      speed_nxt = SPEED_W'(CMD_MAX);
    end else if (cmd_sum < CMD_MIN) begin
      speed_nxt = SPEED_W'(CMD_MIN);
    end else begin
      speed_nxt = SPEED_W'(cmd_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      speed_r <= '0;
    end else if (ctrl.load_out) begin
      integ_r <= integ_nxt;
      speed_r <= speed_nxt;
    end
  end

  assign speed = speed_r;

endmodule

`default_nettype wire
